@@ src/smd_pkg.sv @@
// Shared types, widths and constants for the side marker detector.
`default_nettype none

package smd_pkg;

   localparam int SAMPLE_BITS_DEF = 12;

   localparam int TIME_W     = 32;
   localparam int THR_W      = 12;
   localparam int WIN_W      = 10;
   localparam int HOLD_W     = 16;
   localparam int LIMIT_W    = 4;
   localparam int COUNT_W    = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [WIN_W-1:0]   LEFT_EXPIRY_OFFSET = 10'd50;
   localparam logic [COUNT_W-1:0] COUNT_MAX          = 8'd255;

   localparam logic [THR_W-1:0]   LEFT_THR_RST   = 12'd2000;
   localparam logic [THR_W-1:0]   RIGHT_THR_RST  = 12'd3780;
   localparam logic [WIN_W-1:0]   CROSS_WIN_RST  = 10'd100;
   localparam logic [HOLD_W-1:0]  HOLDOFF_RST    = 16'd200;
   localparam logic [LIMIT_W-1:0] STOP_LIMIT_RST = 4'd2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LEFT_THR   = 3'd0,
      CSR_RIGHT_THR  = 3'd1,
      CSR_CROSS_WIN  = 3'd2,
      CSR_HOLDOFF    = 3'd3,
      CSR_STOP_LIMIT = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [THR_W-1:0]   left_thr;
      logic [THR_W-1:0]   right_thr;
      logic [WIN_W-1:0]   cross_win;
      logic [HOLD_W-1:0]  holdoff;
      logic [LIMIT_W-1:0] stop_limit;
   } cfg_type;

   typedef struct packed {
      logic               left_seen;
      logic               right_seen;
      logic [TIME_W-1:0]  left_stamp;
      logic [TIME_W-1:0]  right_stamp;
      logic [TIME_W-1:0]  holdoff_stamp;
      logic [COUNT_W-1:0] marker_count;
   } track_type;

   typedef struct packed {
      logic               skipped;
      logic               cross_found;
      logic               stop_marker;
      logic [COUNT_W-1:0] marker_total;
      logic               halt;
   } result_type;

endpackage

`default_nettype wire

@@ src/smd_step.sv @@
// Per-item decision logic: hold-off, sighting tracking, crossing and stop marker.
`default_nettype none

module smd_step #(
   parameter int SAMPLE_BITS = smd_pkg::SAMPLE_BITS_DEF
) (
   input  smd_pkg::cfg_type                 cfg,
   input  smd_pkg::track_type               track_cur,
   input  logic [smd_pkg::TIME_W-1:0]       now_ms,
   input  logic [SAMPLE_BITS-1:0]           left_sample,
   input  logic [SAMPLE_BITS-1:0]           right_sample,
   output smd_pkg::track_type               track_nxt,
   output smd_pkg::result_type              result
);
   import smd_pkg::*;

   localparam int CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

   logic               skip;
   logic               lhit;
   logic               rhit;
   logic               released;
   logic               lseen_a;
   logic               rseen_a;
   logic [TIME_W-1:0]  lstamp_a;
   logic [TIME_W-1:0]  rstamp_a;
   logic [WIN_W-1:0]   expiry;
   logic [TIME_W-1:0]  lage;
   logic [TIME_W-1:0]  rage;
   logic [TIME_W-1:0]  win_ext;
   logic               lseen_b;
   logic               cross_a;
   logic               lseen_c;
   logic               rseen_c;
   logic               cross_b;
   logic               stop;
   logic [COUNT_W-1:0] count_nxt;

   always_comb begin
      skip     = (now_ms - track_cur.holdoff_stamp) < TIME_W'(cfg.holdoff);
      lhit     = CMP_W'(left_sample) > CMP_W'(cfg.left_thr);
      rhit     = CMP_W'(right_sample) > CMP_W'(cfg.right_thr);
      released = !lhit || !rhit;

      lseen_a  = track_cur.left_seen || lhit;
      rseen_a  = track_cur.right_seen || rhit;
      lstamp_a = lhit ? now_ms : track_cur.left_stamp;
      rstamp_a = rhit ? now_ms : track_cur.right_stamp;

      expiry   = (cfg.cross_win > LEFT_EXPIRY_OFFSET) ? cfg.cross_win - LEFT_EXPIRY_OFFSET
                                                      : '0;
      win_ext  = TIME_W'(cfg.cross_win);
      lage     = now_ms - lstamp_a;
      rage     = now_ms - rstamp_a;

      // drop a stale left sighting that never found a right partner
      lseen_b  = lseen_a && !((lage >= TIME_W'(expiry)) && !rseen_a);

      cross_a  = lseen_b && rseen_a && (lage < win_ext) && released;
      lseen_c  = lseen_b && !cross_a;
      rseen_c  = rseen_a && !cross_a;

      cross_b  = rseen_c && (rage < win_ext) && lseen_c && released;
      stop     = rseen_c && !cross_b && (rage >= win_ext) && !rhit && !lseen_c;

      count_nxt = track_cur.marker_count;
      if (stop && (track_cur.marker_count < COUNT_MAX)) begin
         count_nxt = track_cur.marker_count + COUNT_W'(1);
      end

      if (skip) begin
         track_nxt           = track_cur;
         result.skipped      = 1'b1;
         result.cross_found  = 1'b0;
         result.stop_marker  = 1'b0;
         result.marker_total = track_cur.marker_count;
         result.halt         = 1'b0;
      end else begin
         track_nxt.left_seen     = lseen_c && !cross_b;
         track_nxt.right_seen    = rseen_c && !cross_b && !stop;
         track_nxt.left_stamp    = lstamp_a;
         track_nxt.right_stamp   = rstamp_a;
         track_nxt.holdoff_stamp = (cross_a || cross_b) ? now_ms : track_cur.holdoff_stamp;
         track_nxt.marker_count  = count_nxt;
         result.skipped          = 1'b0;
         result.cross_found      = cross_a || cross_b;
         result.stop_marker      = stop;
         result.marker_total     = count_nxt;
         result.halt             = count_nxt >= COUNT_W'(cfg.stop_limit);
      end
   end

endmodule

`default_nettype wire

@@ src/side_marker_detector_top.sv @@
// Top level of the side marker detector: channels, registers and state.
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+-----------------------------------------
//  req     | in        | req_valid/req_stall | now_ms, left_sample, right_sample
//  rsp     | out       | rsp_valid/rsp_stall | skipped, cross_found, stop_marker,
//          |           |                    | marker_total, halt
//  csr     | in        | csr_valid/csr_ready | csr_index, csr_wdata (always ready)
//
// One item per cycle sustained unless rsp stalls; each transfer yields one result
// (input register, then the decision logic into the result register).
// The tracking state updates as an item leaves the input register, so the next
// item sees it immediately.
// Reset clears both stages, the tracking state and loads the register defaults;
// the hold-off stamp starts at zero, so early ticks are skipped.
// A stall on rsp holds a valid result in the result register and, once the input
// register is full, raises req_stall in the same cycle.
`default_nettype none

module side_marker_detector_top #(
   parameter int SAMPLE_BITS = smd_pkg::SAMPLE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [smd_pkg::TIME_W-1:0]        req_now_ms,
   input  logic [SAMPLE_BITS-1:0]            req_left_sample,
   input  logic [SAMPLE_BITS-1:0]            req_right_sample,

   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_skipped,
   output logic                              rsp_cross_found,
   output logic                              rsp_stop_marker,
   output logic [smd_pkg::COUNT_W-1:0]       rsp_marker_total,
   output logic                              rsp_halt,

   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [smd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [smd_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import smd_pkg::*;

   // input register
   logic                   in_valid_ff;
   logic [TIME_W-1:0]      in_now_ff;
   logic [SAMPLE_BITS-1:0] in_left_ff;
   logic [SAMPLE_BITS-1:0] in_right_ff;

   // result register
   logic                   out_valid_ff;
   result_type             out_ff;
   result_type             out_in;

   // configuration and tracking state
   cfg_type                cfg_ff;
   cfg_type                cfg_in;
   track_type              track_ff;
   track_type              track_in;

   logic                   out_free;
   logic                   advance;
   logic                   load;

   // the result register can take a new item when empty or being drained
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign load      = req_valid && !req_stall;
   assign req_stall = in_valid_ff && !out_free;
   assign csr_ready = 1'b1;

   smd_step #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_step (
      .cfg          (cfg_ff),
      .track_cur    (track_ff),
      .now_ms       (in_now_ff),
      .left_sample  (in_left_ff),
      .right_sample (in_right_ff),
      .track_nxt    (track_in),
      .result       (out_in)
   );

   // configuration writes; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_LEFT_THR:   cfg_in.left_thr   = csr_wdata[THR_W-1:0];
            CSR_RIGHT_THR:  cfg_in.right_thr  = csr_wdata[THR_W-1:0];
            CSR_CROSS_WIN:  cfg_in.cross_win  = csr_wdata[WIN_W-1:0];
            CSR_HOLDOFF:    cfg_in.holdoff    = csr_wdata[HOLD_W-1:0];
            CSR_STOP_LIMIT: cfg_in.stop_limit = csr_wdata[LIMIT_W-1:0];
            default:        cfg_in            = cfg_ff;
         endcase
      end
   end

   // control and state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff          <= 1'b0;
         out_valid_ff         <= 1'b0;
         cfg_ff.left_thr      <= LEFT_THR_RST;
         cfg_ff.right_thr     <= RIGHT_THR_RST;
         cfg_ff.cross_win     <= CROSS_WIN_RST;
         cfg_ff.holdoff       <= HOLDOFF_RST;
         cfg_ff.stop_limit    <= STOP_LIMIT_RST;
         track_ff             <= '0;
      end else begin
         cfg_ff <= cfg_in;
         // hold the input stage while its item cannot move on
         if (load) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
         // advance the tracking state with the item that moves forward
         if (advance) begin
            track_ff <= track_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (load) begin
         in_now_ff   <= req_now_ms;
         in_left_ff  <= req_left_sample;
         in_right_ff <= req_right_sample;
      end
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_skipped      = out_ff.skipped;
   assign rsp_cross_found  = out_ff.cross_found;
   assign rsp_stop_marker  = out_ff.stop_marker;
   assign rsp_marker_total = out_ff.marker_total;
   assign rsp_halt         = out_ff.halt;

endmodule

`default_nettype wire

@@ src/smd_checker.sv @@
// Port-level checks for the side marker detector, bound to the top level.
`default_nettype none

module smd_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic                        rsp_skipped,
   input logic                        rsp_cross_found,
   input logic                        rsp_stop_marker,
   input logic [smd_pkg::COUNT_W-1:0] rsp_marker_total,
   input logic                        rsp_halt
);

   // a stalled result keeps its content
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_skipped)
         && $stable(rsp_cross_found) && $stable(rsp_stop_marker)
         && $stable(rsp_marker_total) && $stable(rsp_halt))
      else $error("stalled result changed");

   // a skipped item reports no events and no halt
   a_skip_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_skipped |-> !rsp_cross_found && !rsp_stop_marker && !rsp_halt)
      else $error("skipped item carries events");

   // one item never completes a crossing and counts a stop marker at once
   a_event_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_cross_found && rsp_stop_marker))
      else $error("crossing and stop marker on one item");

   // a counted stop marker leaves a nonzero total
   a_stop_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stop_marker |-> rsp_marker_total != '0)
      else $error("stop marker with zero total");

endmodule

bind side_marker_detector_top smd_checker u_smd_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_skipped      (rsp_skipped),
   .rsp_cross_found  (rsp_cross_found),
   .rsp_stop_marker  (rsp_stop_marker),
   .rsp_marker_total (rsp_marker_total),
   .rsp_halt         (rsp_halt)
);

`default_nettype wire

@@ tb/side_marker_detector_checker.sv @@
// Side marker detector checker: watches all channels, predicts each result and compares it.
module side_marker_detector_checker (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [smd_pkg::TIME_W-1:0]     req_now_ms,
   input  logic [smd_pkg::THR_W-1:0]      req_left_sample,
   input  logic [smd_pkg::THR_W-1:0]      req_right_sample,

   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic                           rsp_skipped,
   input  logic                           rsp_cross_found,
   input  logic                           rsp_stop_marker,
   input  logic [smd_pkg::COUNT_W-1:0]    rsp_marker_total,
   input  logic                           rsp_halt,

   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [smd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [smd_pkg::CSR_DATA_W-1:0] csr_wdata,

   output int                             mismatch_count,
   output int                             awaiting,
   output int                             checked_total,
   output int                             crossing_total,
   output int                             stop_total,
   output int                             skip_total
);
   timeunit 1ns;
   timeprecision 1ps;
   import smd_pkg::*;

   cfg_type    regs;
   track_type  track;
   result_type expected_results[$];
   int         fails;
   int         checked;
   int         crossings;
   int         stops;
   int         skips;

   initial begin
      fails          = 0;
      checked        = 0;
      crossings      = 0;
      stops          = 0;
      skips          = 0;
   end

   // Work out the result of one sample pair and advance the tracking state.
   function automatic result_type judge_sample(input logic [TIME_W-1:0] now,
                                               input logic [THR_W-1:0]  ls,
                                               input logic [THR_W-1:0]  rs);
      result_type        res;
      logic              lhit;
      logic              rhit;
      logic              released;
      logic [TIME_W-1:0] hold_age;
      logic [TIME_W-1:0] left_age;
      logic [TIME_W-1:0] right_age;
      logic [WIN_W-1:0]  expiry;
      res = '0;
      hold_age = now - track.holdoff_stamp;
      if (hold_age < {16'd0, regs.holdoff}) begin
         res.skipped      = 1'b1;
         res.marker_total = track.marker_count;
         return res;
      end
      lhit     = ls > regs.left_thr;
      rhit     = rs > regs.right_thr;
      released = !lhit || !rhit;
      if (lhit) begin
         track.left_stamp = now;
         track.left_seen  = 1'b1;
      end
      if (rhit) begin
         track.right_stamp = now;
         track.right_seen  = 1'b1;
      end
      expiry = (regs.cross_win > LEFT_EXPIRY_OFFSET) ? regs.cross_win - LEFT_EXPIRY_OFFSET
                                                      : '0;
      left_age = now - track.left_stamp;
      if (track.left_seen && left_age >= {22'd0, expiry} && !track.right_seen)
         track.left_seen = 1'b0;
      if (track.left_seen && track.right_seen && left_age < {22'd0, regs.cross_win}
          && released) begin
         track.left_seen     = 1'b0;
         track.right_seen    = 1'b0;
         track.holdoff_stamp = now;
         res.cross_found     = 1'b1;
      end
      if (track.right_seen) begin
         right_age = now - track.right_stamp;
         if (right_age < {22'd0, regs.cross_win} && track.left_seen && released) begin
            track.left_seen     = 1'b0;
            track.right_seen    = 1'b0;
            track.holdoff_stamp = now;
            res.cross_found     = 1'b1;
         end else if (right_age >= {22'd0, regs.cross_win} && !rhit && !track.left_seen) begin
            if (track.marker_count != COUNT_MAX)
               track.marker_count = track.marker_count + 1'b1;
            track.right_seen = 1'b0;
            res.stop_marker  = 1'b1;
         end
      end
      res.marker_total = track.marker_count;
      res.halt         = track.marker_count >= {4'd0, regs.stop_limit};
      return res;
   endfunction

   function automatic string show_result(input result_type r);
      return $sformatf("skipped=%0d cross=%0d stop=%0d total=%0d halt=%0d",
                       r.skipped, r.cross_found, r.stop_marker, r.marker_total, r.halt);
   endfunction

   always @(posedge clock) begin : watch
      result_type got;
      result_type exp;
      if (reset) begin
         regs.left_thr   = LEFT_THR_RST;
         regs.right_thr  = RIGHT_THR_RST;
         regs.cross_win  = CROSS_WIN_RST;
         regs.holdoff    = HOLDOFF_RST;
         regs.stop_limit = STOP_LIMIT_RST;
         track = '0;
         expected_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_LEFT_THR:   regs.left_thr   = csr_wdata[THR_W-1:0];
               CSR_RIGHT_THR:  regs.right_thr  = csr_wdata[THR_W-1:0];
               CSR_CROSS_WIN:  regs.cross_win  = csr_wdata[WIN_W-1:0];
               CSR_HOLDOFF:    regs.holdoff    = csr_wdata[HOLD_W-1:0];
               CSR_STOP_LIMIT: regs.stop_limit = csr_wdata[LIMIT_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            got.skipped      = rsp_skipped;
            got.cross_found  = rsp_cross_found;
            got.stop_marker  = rsp_stop_marker;
            got.marker_total = rsp_marker_total;
            got.halt         = rsp_halt;
            if (expected_results.size() == 0) begin
               fails++;
               if (fails <= 10)
                  $display("%0t: result with nothing pending: %s", $time, show_result(got));
            end else begin
               exp = expected_results.pop_front();
               checked++;
               if (got !== exp) begin
                  fails++;
                  if (fails <= 10)
                     $display("%0t: result %0d mismatch\n   expected %s\n   actual   %s",
                              $time, checked, show_result(exp), show_result(got));
               end
            end
         end
         if (req_valid && !req_stall) begin
            exp = judge_sample(req_now_ms, req_left_sample, req_right_sample);
            crossings += exp.cross_found;
            stops     += exp.stop_marker;
            skips     += exp.skipped;
            expected_results.push_back(exp);
         end
      end
      mismatch_count <= fails;
      awaiting       <= expected_results.size();
      checked_total  <= checked;
      crossing_total <= crossings;
      stop_total     <= stops;
      skip_total     <= skips;
   end

endmodule

@@ tb/side_marker_detector_top_tb.sv @@
// Testbench top for the side marker detector: clock, reset, stimulus, stalls and verdict.
module side_marker_detector_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import smd_pkg::*;

   // Register index that maps to no register; writes to it must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_NO_REG = 3'd7;
   localparam int CYCLE_LIMIT = 600_000;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [TIME_W-1:0]     req_now_ms;
   logic [THR_W-1:0]      req_left_sample;
   logic [THR_W-1:0]      req_right_sample;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic                  rsp_skipped;
   logic                  rsp_cross_found;
   logic                  rsp_stop_marker;
   logic [COUNT_W-1:0]    rsp_marker_total;
   logic                  rsp_halt;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int chk_mismatches;
   int chk_awaiting;
   int chk_checked;
   int chk_crossings;
   int chk_stops;
   int chk_skips;

   cfg_type           cur_cfg;       // register values the block holds now
   logic [TIME_W-1:0] now_tick;      // millisecond clock of the simulated robot
   bit                steady;        // no sender gaps during this episode
   int                items_sent;
   int                setting_count;
   int                cycle_count;

   side_marker_detector_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_now_ms       (req_now_ms),
      .req_left_sample  (req_left_sample),
      .req_right_sample (req_right_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_skipped      (rsp_skipped),
      .rsp_cross_found  (rsp_cross_found),
      .rsp_stop_marker  (rsp_stop_marker),
      .rsp_marker_total (rsp_marker_total),
      .rsp_halt         (rsp_halt),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   side_marker_detector_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_now_ms       (req_now_ms),
      .req_left_sample  (req_left_sample),
      .req_right_sample (req_right_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_skipped      (rsp_skipped),
      .rsp_cross_found  (rsp_cross_found),
      .rsp_stop_marker  (rsp_stop_marker),
      .rsp_marker_total (rsp_marker_total),
      .rsp_halt         (rsp_halt),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatch_count   (chk_mismatches),
      .awaiting         (chk_awaiting),
      .checked_total    (chk_checked),
      .crossing_total   (chk_crossings),
      .stop_total       (chk_stops),
      .skip_total       (chk_skips)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog: end the run if the block hangs.
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, chk_awaiting);
            $display("[side_marker_detector_top] ERROR");
            $finish;
         end
      end
   end

   // Result side back-pressure: mostly short free runs and short stalls, now and
   // then a long free run or a long stall. Change only at the falling edge.
   initial begin : stall_driver
      int pick;
      int len;
      logic level;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            level = 1'b0;
            len   = $urandom_range(1, 8);
         end else if (pick < 85) begin
            level = 1'b1;
            len   = $urandom_range(1, 3);
         end else if (pick < 95) begin
            level = 1'b0;
            len   = $urandom_range(30, 80);
         end else begin
            level = 1'b1;
            len   = $urandom_range(10, 40);
         end
         rsp_stall <= level;
         repeat (len - 1) @(negedge clock);
      end
   end

   // Sample levels relative to the current thresholds. A threshold at full scale
   // cannot be exceeded, so "above" then returns full scale without a hit.
   function automatic logic [THR_W-1:0] above(input logic [THR_W-1:0] thr);
      if (thr == '1)
         return thr;
      return THR_W'($urandom_range(32'(thr) + 1, 4095));
   endfunction

   function automatic logic [THR_W-1:0] below(input logic [THR_W-1:0] thr);
      return THR_W'($urandom_range(0, 32'(thr)));
   endfunction

   function automatic int unsigned win_step();
      return $urandom_range(0, 32'(cur_cfg.cross_win) / 3 + 2);
   endfunction

   // Offer one sample pair and hold it until the transfer happens. A gap, when
   // chosen, drops valid first.
   task automatic offer_sample(input logic [TIME_W-1:0] now,
                               input logic [THR_W-1:0]  ls,
                               input logic [THR_W-1:0]  rs);
      int pick;
      int gap;
      pick = $urandom_range(0, 99);
      if (steady || pick < 70)
         gap = 0;
      else if (pick < 93)
         gap = $urandom_range(1, 3);
      else
         gap = $urandom_range(8, 30);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_now_ms       <= now;
      req_left_sample  <= ls;
      req_right_sample <= rs;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0]  idx,
                                 input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Load a full register setting; the unused upper data bits, where there are any, carry junk.
   task automatic load_config(input cfg_type c);
      write_register(CSR_LEFT_THR,   {4'($urandom), c.left_thr});
      write_register(CSR_RIGHT_THR,  {4'($urandom), c.right_thr});
      write_register(CSR_CROSS_WIN,  {6'($urandom), c.cross_win});
      write_register(CSR_HOLDOFF,    c.holdoff);
      write_register(CSR_STOP_LIMIT, {12'($urandom), c.stop_limit});
      cur_cfg = c;
      setting_count++;
   endtask

   // Drop valid and wait until every result has come back.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (chk_awaiting != 0) @(negedge clock);
   endtask

   // One short scene: a crossing, a stop marker, a lone left or right mark, or noise.
   task automatic run_episode(input bit stop_heavy);
      int  kind;
      int  n;
      bit  right_first;
      steady = ($urandom_range(0, 4) == 0);
      // advance past a running hold-off now and then, or jump anywhere on the clock
      if ($urandom_range(0, 2) == 0)
         now_tick += cur_cfg.holdoff + $urandom_range(0, 20);
      if ($urandom_range(0, 49) == 0)
         now_tick = $urandom;
      kind = $urandom_range(0, 9);
      if (stop_heavy)
         kind = (kind < 8) ? 4 : 8;
      case (kind)
         0, 1, 2, 3: begin
            right_first = $urandom_range(0, 1);
            n = $urandom_range(1, 3);
            repeat (n) begin
               now_tick += win_step();
               if (right_first)
                  offer_sample(now_tick, below(cur_cfg.left_thr), above(cur_cfg.right_thr));
               else
                  offer_sample(now_tick, above(cur_cfg.left_thr), below(cur_cfg.right_thr));
            end
            n = $urandom_range(1, 2);
            repeat (n) begin
               now_tick += win_step();
               offer_sample(now_tick, above(cur_cfg.left_thr), above(cur_cfg.right_thr));
            end
            now_tick += win_step();
            case ($urandom_range(0, 2))
               0: offer_sample(now_tick, below(cur_cfg.left_thr), above(cur_cfg.right_thr));
               1: offer_sample(now_tick, above(cur_cfg.left_thr), below(cur_cfg.right_thr));
               default:
                  offer_sample(now_tick, below(cur_cfg.left_thr), below(cur_cfg.right_thr));
            endcase
         end
         4, 5: begin
            n = stop_heavy ? 1 : $urandom_range(1, 4);
            repeat (n) begin
               now_tick += win_step();
               offer_sample(now_tick, below(cur_cfg.left_thr), above(cur_cfg.right_thr));
            end
            now_tick += cur_cfg.cross_win + $urandom_range(0, 40);
            offer_sample(now_tick, below(cur_cfg.left_thr), below(cur_cfg.right_thr));
         end
         6: begin
            now_tick += win_step();
            offer_sample(now_tick, above(cur_cfg.left_thr), below(cur_cfg.right_thr));
            now_tick += $urandom_range(0, 32'(cur_cfg.cross_win));
            offer_sample(now_tick, below(cur_cfg.left_thr), below(cur_cfg.right_thr));
         end
         7: begin
            now_tick += win_step();
            offer_sample(now_tick, below(cur_cfg.left_thr), above(cur_cfg.right_thr));
            now_tick += win_step();
            offer_sample(now_tick, below(cur_cfg.left_thr), below(cur_cfg.right_thr));
         end
         default: begin
            n = $urandom_range(1, 3);
            repeat (n) begin
               now_tick += $urandom_range(0, 60);
               offer_sample(now_tick, THR_W'($urandom), THR_W'($urandom));
            end
         end
      endcase
   endtask

   // Load a setting, play random scenes until enough items went out, then drain.
   task automatic run_phase(input cfg_type c, input int count, input bit stop_heavy);
      int target;
      load_config(c);
      target = items_sent + count;
      while (items_sent < target)
         run_episode(stop_heavy);
      drain_results();
   endtask

   initial begin : stimulus
      cfg_type c;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_now_ms       = '0;
      req_left_sample  = '0;
      req_right_sample = '0;
      csr_valid        = 1'b0;
      csr_index        = CSR_LEFT_THR;
      csr_wdata        = '0;
      steady           = 1'b0;
      items_sent       = 0;
      setting_count    = 1;
      cur_cfg = '{LEFT_THR_RST, RIGHT_THR_RST, CROSS_WIN_RST, HOLDOFF_RST, STOP_LIMIT_RST};
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Directed scenes with the register defaults.
      // hold-off right after reset: early ticks are skipped
      offer_sample(32'd0,   12'd4095, 12'd4095);
      offer_sample(32'd199, 12'd0,    12'd0);
      offer_sample(32'd200, 12'd0,    12'd0);
      // levels exactly at the thresholds are no hit
      offer_sample(32'd300, 12'd2000, 12'd3780);
      // left then both then release: a crossing, followed by a skipped item
      offer_sample(32'd310, 12'd2001, 12'd0);
      offer_sample(32'd320, 12'd4095, 12'd3781);
      offer_sample(32'd330, 12'd0,    12'd0);
      offer_sample(32'd400, 12'd4095, 12'd4095);
      // two right-only marks that outlast the window: two stop markers, halt
      offer_sample(32'd530, 12'd0,    12'd4095);
      offer_sample(32'd580, 12'd0,    12'd4095);
      offer_sample(32'd700, 12'd0,    12'd0);
      offer_sample(32'd710, 12'd0,    12'd4095);
      offer_sample(32'd850, 12'd0,    12'd0);
      // lone left mark expires
      offer_sample(32'd900, 12'd4095, 12'd0);
      offer_sample(32'd960, 12'd0,    12'd0);
      // stale left with a fresh right still pairs through the right-side path
      offer_sample(32'd970,  12'd4095, 12'd0);
      offer_sample(32'd1100, 12'd0,    12'd4095);
      // crossing across the tick wrap, then hold-off edges after the wrap
      offer_sample(32'hFFFF_FFF0, 12'd4095, 12'd4095);
      offer_sample(32'h0000_0005, 12'd0,    12'd0);
      offer_sample(32'h0000_00CC, 12'd4095, 12'd4095);
      offer_sample(32'h0000_00CD, 12'd0,    12'd0);
      offer_sample(32'hFFFF_FFFF, 12'd4095, 12'd0);
      drain_results();
      now_tick = $urandom;

      // typical thresholds and windows
      c.left_thr   = THR_W'($urandom_range(500, 3500));
      c.right_thr  = THR_W'($urandom_range(500, 3500));
      c.cross_win  = WIN_W'($urandom_range(100, 300));
      c.holdoff    = HOLD_W'(200);
      c.stop_limit = LIMIT_W'(2);
      run_phase(c, 200, 1'b0);

      // zero thresholds, widest window, no hold-off, top stop limit
      c = '{'0, '0, '1, '0, '1};
      run_phase(c, 200, 1'b0);

      // unreachable thresholds, narrowest usual window, longest hold-off
      c = '{'1, '1, WIN_W'(50), '1, LIMIT_W'(1)};
      run_phase(c, 100, 1'b0);

      // window below the left expiry offset, zero stop limit: halt on every live item
      c.left_thr   = THR_W'($urandom_range(200, 3900));
      c.right_thr  = THR_W'($urandom_range(200, 3900));
      c.cross_win  = WIN_W'($urandom_range(1, 49));
      c.holdoff    = HOLD_W'($urandom_range(0, 300));
      c.stop_limit = '0;
      run_phase(c, 150, 1'b0);

      // zero window and no hold-off: stop markers come fast, drive the count to saturation
      c.left_thr   = THR_W'($urandom_range(200, 3900));
      c.right_thr  = THR_W'($urandom_range(200, 3900));
      c.cross_win  = '0;
      c.holdoff    = '0;
      c.stop_limit = LIMIT_W'(15);
      run_phase(c, 700, 1'b1);

      // a write to an unused index changes nothing, then a fully random setting
      write_register(CSR_NO_REG, CSR_DATA_W'($urandom));
      c = cfg_type'($urandom());
      c.left_thr  = THR_W'($urandom);
      c.right_thr = THR_W'($urandom);
      c.cross_win = WIN_W'($urandom);
      c.holdoff   = HOLD_W'($urandom_range(0, 600));
      run_phase(c, 300, 1'b0);

      // let any stray result show up before the verdict
      repeat (8) @(posedge clock);
      $display("Sent %0d sample pairs under %0d register settings, %0d results checked.",
               items_sent, setting_count, chk_checked);
      $display("Saw %0d crossings, %0d stop markers and %0d skipped items.",
               chk_crossings, chk_stops, chk_skips);
      if (chk_mismatches == 0)
         $display("[side_marker_detector_top] OK");
      else
         $display("[side_marker_detector_top] ERROR");
      $finish;
   end

endmodule

@@ sim.f @@
src/smd_pkg.sv
src/smd_step.sv
src/side_marker_detector_top.sv
src/smd_checker.sv
tb/side_marker_detector_checker.sv
tb/side_marker_detector_top_tb.sv
